// ----- sv/rdwt_pkg.sv -----
package rdwt_pkg;

    localparam int DEVICE_SLOTS_DEF       = 16;
    localparam int SAMPLES_PER_DEVICE_DEF = 32;

    localparam int MAC_W    = 48;
    localparam int RSSI_W   = 8;
    localparam int TIME_W   = 32;
    localparam int ENTRY_W  = TIME_W + RSSI_W;
    localparam int AVG_W    = 12;
    localparam int SCNT_W   = 6;
    localparam int RCNT_W   = 10;
    localparam int AGE_W    = 8;

    localparam logic [AVG_W-1:0] NO_DATA_X16 = 12'(-1520);
    localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd1;

    // operation codes
    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_AGE    = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // divider handshake status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- sv/rdwt_mem.sv -----
module rdwt_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/rdwt_div.sv -----
module rdwt_div #(
    parameter int NW = 19,
    parameter int CW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NW-1:0]         i_dividend,
    input  logic [CW-1:0]         i_divisor,
    output rdwt_pkg::t_div_stat   o_stat,
    output logic [NW-1:0]         o_quotient
);
    import rdwt_pkg::*;

    localparam int SW = (NW > 1) ? $clog2(NW + 1) : 1;

    logic [CW:0]   r_rem,  n_rem;
    logic [NW-1:0] r_q,    n_q;
    logic [CW-1:0] r_div,  n_div;
    logic [SW-1:0] r_step, n_step;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW+1:0] trial;
    logic [CW:0]   shifted;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_rem   = r_rem;
        n_q     = r_q;
        n_div   = r_div;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        shifted = {r_rem[CW-1:0], r_q[NW-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div};
        if (i_start) begin
            n_rem  = '0;
            n_q    = i_dividend;
            n_div  = i_divisor;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[CW+1]) begin
                n_rem = trial[CW:0];
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_step = r_step + 1'b1;
            if (r_step == SW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_div  <= n_div;
        r_step <= n_step;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;
endmodule

// ----- sv/rssi_device_window_table.sv -----
// RSSI device window table
// Input channel i_valid/o_ready carries one operation (record, query, age,
// clear) with MAC, RSSI sample and current time. Output channel
// o_valid/i_ready carries one result per operation: status, mean RSSI x16,
// sample count and removed count. i_cfg_we writes max_age_seconds at once.
// One operation is processed at a time; o_ready is high only when idle.
// Device lookup walks up to DEVICE_SLOTS slots, one per cycle. Record adds
// a write state; record and query then read the window from the sample
// memory, one entry per cycle, and divide one quotient bit per cycle
// (13 + clog2(SAMPLES_PER_DEVICE + 1) quotient bits). Age visits each slot,
// reading the head sample of each live window and removing old samples
// one at a time until the head is young enough or the window is empty.
// Clear empties the table and goes from idle straight to the done state.
// Results are held in an output register; a stalled receiver holds the
// previous result there and the finished one waits in the done state.
// Synchronous reset empties the table (valid bits and counters only, no
// memory sweep) and sets max_age_seconds to 1.
module rssi_device_window_table #(
    parameter int DEVICE_SLOTS       = rdwt_pkg::DEVICE_SLOTS_DEF,
    parameter int SAMPLES_PER_DEVICE = rdwt_pkg::SAMPLES_PER_DEVICE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [rdwt_pkg::MAC_W-1:0]  i_mac,
    input  logic signed [rdwt_pkg::RSSI_W-1:0] i_rssi,
    input  logic [rdwt_pkg::TIME_W-1:0] i_now_sec,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic signed [rdwt_pkg::AVG_W-1:0] o_average_x16,
    output logic [rdwt_pkg::SCNT_W-1:0] o_sample_count,
    output logic [rdwt_pkg::RCNT_W-1:0] o_removed_count,
    input  logic                        i_cfg_we,
    input  logic [rdwt_pkg::AGE_W-1:0]  i_cfg_data
);
    import rdwt_pkg::*;

    localparam int D  = DEVICE_SLOTS;
    localparam int S  = SAMPLES_PER_DEVICE;
    localparam int IW = (D > 1) ? $clog2(D) : 1;
    localparam int HW = (S > 1) ? $clog2(S) : 1;
    localparam int CW = $clog2(S + 1);
    localparam int DEPTH = D * S;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = 9 + CW;
    localparam int NW = SW + 4;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_WRITE  = 8'b0000_0100,
        S_MEAN   = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_AGECHK = 8'b0010_0000,
        S_AGECMP = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // device table
    logic [MAC_W-1:0] r_tmac  [D];
    logic             r_dv    [D];
    logic [HW-1:0]    r_head  [D];
    logic [CW-1:0]    r_cnt   [D];

    logic          tbl_we, tbl_mac_we, tbl_valid, tbl_clear;
    logic [IW-1:0] tbl_idx;
    logic [HW-1:0] tbl_head;
    logic [CW-1:0] tbl_cnt;

    // captured operation
    logic [1:0]        r_mode;
    logic [MAC_W-1:0]  r_mac;
    logic [RSSI_W-1:0] r_rssi;
    logic [TIME_W-1:0] r_now;
    logic [AGE_W-1:0]  r_max_age;

    logic [IW-1:0] r_idx,      n_idx;
    logic          r_free_ok,  n_free_ok;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_dev,      n_dev;
    logic [HW-1:0] r_wpos,     n_wpos;
    logic [HW-1:0] r_pos,      n_pos;
    logic [CW-1:0] r_n,        n_n;
    logic [CW-1:0] r_k,        n_k;
    logic          r_pend,     n_pend;
    logic signed [SW-1:0] r_sum, n_sum;
    logic          r_neg,      n_neg;
    logic [RCNT_W-1:0] r_rem,  n_rem;

    logic [1:0]          r_st,  n_st;
    logic [AVG_W-1:0]    r_avg, n_avg;
    logic [SCNT_W-1:0]   r_sc,  n_sc;
    logic [RCNT_W-1:0]   r_rc,  n_rc;
    logic                r_ovalid;

    // output register
    logic [1:0]          r_ost;
    logic [AVG_W-1:0]    r_oavg;
    logic [SCNT_W-1:0]   r_osc;
    logic [RCNT_W-1:0]   r_orc;

    // memory and divider hookup
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic              div_start;
    logic [NW-1:0]     div_dividend, div_q;
    t_div_stat         div_stat;

    // search and append helpers
    logic          hit, last, free_now_ok, go;
    logic [IW-1:0] free_now_idx, sel_d;
    logic [HW-1:0] sel_h, app_h;
    logic [CW-1:0] sel_c, app_c;
    logic [CW:0]   app_sum;
    logic [SW-1:0] abs_sum;
    logic [TIME_W:0] age_diff;
    logic          age_old;

    function automatic logic [HW-1:0] pos_inc(input logic [HW-1:0] p);
        logic [HW-1:0] r;
        r = (p == HW'(S - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_ready = (r_state == S_IDLE);

    assign hit          = r_dv[r_idx] && (r_tmac[r_idx] == r_mac);
    assign last         = (r_idx == IW'(D - 1));
    assign free_now_ok  = r_free_ok || !r_dv[r_idx];
    assign free_now_idx = r_free_ok ? r_free_idx : r_idx;
    assign abs_sum      = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign div_dividend = {abs_sum, 4'b0000};
    assign age_diff     = {1'b0, r_now} - {1'b0, mem_rdata[ENTRY_W-1:RSSI_W]};
    assign age_old      = !age_diff[TIME_W] && (age_diff[TIME_W-1:0] > TIME_W'(r_max_age));

    // main sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_dev      = r_dev;
        n_wpos     = r_wpos;
        n_pos      = r_pos;
        n_n        = r_n;
        n_k        = r_k;
        n_pend     = 1'b0;
        n_sum      = r_sum;
        n_neg      = r_neg;
        n_rem      = r_rem;
        n_st       = r_st;
        n_avg      = r_avg;
        n_sc       = r_sc;
        n_rc       = r_rc;
        tbl_we     = 1'b0;
        tbl_mac_we = 1'b0;
        tbl_valid  = 1'b1;
        tbl_clear  = 1'b0;
        tbl_idx    = r_idx;
        tbl_head   = '0;
        tbl_cnt    = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = AW'(AW'(r_dev) * AW'(S) + AW'(r_wpos));
        mem_raddr  = AW'(AW'(r_dev) * AW'(S) + AW'(r_pos));
        div_start  = 1'b0;
        go         = 1'b0;
        sel_d      = r_idx;
        sel_h      = r_head[r_idx];
        sel_c      = r_cnt[r_idx];
        app_h      = sel_h;
        app_c      = sel_c;
        app_sum    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_idx     = '0;
                    n_free_ok = 1'b0;
                    n_rem     = '0;
                    case (i_mode)
                        MODE_RECORD, MODE_QUERY: n_state = S_SEARCH;
                        MODE_AGE:                n_state = S_AGECHK;
                        default: begin
                            tbl_clear = 1'b1;
                            n_st      = ST_OK;
                            n_avg     = '0;
                            n_sc      = '0;
                            n_rc      = '0;
                            n_state   = S_DONE;
                        end
                    endcase
                end
            end

            // walk the slots for a matching mac, note the first free one
            S_SEARCH: begin
                n_free_ok  = free_now_ok;
                n_free_idx = free_now_idx;
                n_idx      = r_idx + 1'b1;
                if (hit) begin
                    go = 1'b1;
                end else if (last) begin
                    if (r_mode == MODE_QUERY) begin
                        n_st = ST_UNKNOWN; n_avg = NO_DATA_X16; n_sc = '0; n_rc = '0;
                        n_state = S_DONE;
                    end else if (!free_now_ok) begin
                        n_st = ST_FULL; n_avg = NO_DATA_X16; n_sc = '0; n_rc = '0;
                        n_state = S_DONE;
                    end else begin
                        go         = 1'b1;
                        sel_d      = free_now_idx;
                        sel_h      = '0;
                        sel_c      = '0;
                        tbl_mac_we = 1'b1;
                    end
                end
                if (go) begin
                    n_dev   = sel_d;
                    n_k     = '0;
                    n_sum   = '0;
                    tbl_idx = sel_d;
                    if (r_mode == MODE_QUERY) begin
                        n_n   = sel_c;
                        n_pos = sel_h;
                        if (sel_c == '0) begin
                            n_st = ST_EMPTY; n_avg = NO_DATA_X16; n_sc = '0; n_rc = '0;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MEAN;
                        end
                    end else begin
                        // full window drops its oldest sample
                        if (sel_c == CW'(S)) begin
                            app_h = pos_inc(sel_h);
                            app_c = CW'(S - 1);
                        end else begin
                            app_h = sel_h;
                            app_c = sel_c;
                        end
                        app_sum  = {1'b0, CW'(app_h)} + {1'b0, app_c};
                        n_wpos   = (app_sum >= (CW + 1)'(S)) ? HW'(app_sum - (CW + 1)'(S))
                                                             : HW'(app_sum);
                        tbl_we   = 1'b1;
                        tbl_head = app_h;
                        tbl_cnt  = app_c + 1'b1;
                        n_n      = app_c + 1'b1;
                        n_pos    = app_h;
                        n_state  = S_WRITE;
                    end
                end
            end

            S_WRITE: begin
                mem_we  = 1'b1;
                n_state = S_MEAN;
            end

            // stream the window out of memory, one read per cycle
            S_MEAN: begin
                if (r_k != r_n) begin
                    mem_re = 1'b1;
                    n_pos  = pos_inc(r_pos);
                    n_k    = r_k + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_sum = r_sum + {{(SW - RSSI_W){mem_rdata[RSSI_W-1]}},
                                     mem_rdata[RSSI_W-1:0]};
                end
                if (r_k == r_n && !r_pend) begin
                    div_start = 1'b1;
                    n_neg     = r_sum[SW-1];
                    n_state   = S_DIV;
                end
            end

            S_DIV: begin
                if (div_stat.done) begin
                    n_st    = ST_OK;
                    n_avg   = r_neg ? AVG_W'(-div_q) : AVG_W'(div_q);
                    n_sc    = SCNT_W'(r_n);
                    n_rc    = '0;
                    n_state = S_DONE;
                end
            end

            // age: look at the head sample of each live window
            S_AGECHK: begin
                mem_raddr = AW'(AW'(r_idx) * AW'(S) + AW'(r_head[r_idx]));
                if (r_dv[r_idx] && r_cnt[r_idx] != '0) begin
                    mem_re  = 1'b1;
                    n_state = S_AGECMP;
                end else if (last) begin
                    n_st = ST_OK; n_avg = '0; n_sc = '0; n_rc = r_rem;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_AGECMP: begin
                if (age_old) begin
                    tbl_we   = 1'b1;
                    tbl_head = pos_inc(r_head[r_idx]);
                    tbl_cnt  = r_cnt[r_idx] - 1'b1;
                    n_rem    = r_rem + 1'b1;
                    n_state  = S_AGECHK;
                end else if (last) begin
                    n_st = ST_OK; n_avg = '0; n_sc = '0; n_rc = r_rem;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_AGECHK;
                end
            end

            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_pend    <= 1'b0;
            r_max_age <= MAX_AGE_RST;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result moves to the output register when the done state hands it over
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || i_ready)) begin
            r_ost  <= r_st;
            r_oavg <= r_avg;
            r_osc  <= r_sc;
            r_orc  <= r_rc;
        end
    end

    // operand and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= i_mode;
            r_mac  <= i_mac;
            r_rssi <= i_rssi;
            r_now  <= i_now_sec;
        end
        r_idx      <= n_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_dev      <= n_dev;
        r_wpos     <= n_wpos;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_k        <= n_k;
        r_sum      <= n_sum;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_st       <= n_st;
        r_avg      <= n_avg;
        r_sc       <= n_sc;
        r_rc       <= n_rc;
    end

    // device table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || tbl_clear) begin
            for (int i = 0; i < D; i++) begin
                r_dv[i]   <= 1'b0;
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (tbl_we) begin
            r_dv[tbl_idx]   <= tbl_valid;
            r_head[tbl_idx] <= tbl_head;
            r_cnt[tbl_idx]  <= tbl_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_mac_we) begin
            r_tmac[tbl_idx] <= r_mac;
        end
    end

    rdwt_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({r_now, r_rssi}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rdwt_div #(
        .NW (NW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_n),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    assign o_valid         = r_ovalid;
    assign o_status        = r_ost;
    assign o_average_x16   = r_oavg;
    assign o_sample_count  = r_osc;
    assign o_removed_count = r_orc;
endmodule

// ----- tb/tb_rssi_device_window_table.sv -----
module tb_rssi_device_window_table;
    import rdwt_pkg::*;

    localparam int SLOTS = DEVICE_SLOTS_DEF;
    localparam int DEPTH = SAMPLES_PER_DEVICE_DEF;
    localparam longint CYCLE_LIMIT = 10000000;

    // one operation and one result
    typedef struct {
        logic [1:0]         mode;
        logic [MAC_W-1:0]   mac;
        logic [RSSI_W-1:0]  rssi;
        logic [TIME_W-1:0]  now_sec;
    } t_op;

    typedef struct {
        logic [1:0]        status;
        logic [AVG_W-1:0]  avg;
        logic [SCNT_W-1:0] cnt;
        logic [RCNT_W-1:0] removed;
    } t_res;

    // predictor of the window table plus queue of pending results
    class window_table_scoreboard;
        logic [MAC_W-1:0]   macs [SLOTS];
        bit                 used [SLOTS];
        logic [RSSI_W-1:0]  rssi_mem [SLOTS][DEPTH];
        logic [TIME_W-1:0]  stamp_mem [SLOTS][DEPTH];
        int                 head [SLOTS];
        int                 count [SLOTS];
        logic [AGE_W-1:0]   max_age;
        t_res               pending [$];
        int                 errors;

        function new();
            max_age = MAX_AGE_RST;
            errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0;
                head[i] = 0;
                count[i] = 0;
            end
        endfunction

        function int lookup(logic [MAC_W-1:0] mac);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && macs[i] == mac) return i;
            return -1;
        endfunction

        function logic [AVG_W-1:0] mean_x16(int d);
            int sum;
            sum = 0;
            for (int k = 0; k < count[d]; k++)
                sum += $signed(rssi_mem[d][(head[d] + k) % DEPTH]);
            return AVG_W'((sum * 16) / count[d]);
        endfunction

        function void note_op(t_op op);
            t_res r;
            int d;
            int f;
            longint age;
            r = '{ST_OK, '0, '0, '0};
            case (op.mode)
                MODE_RECORD: begin
                    d = lookup(op.mac);
                    if (d < 0) begin
                        f = -1;
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!used[i]) f = i;
                        if (f >= 0) begin
                            d = f;
                            used[d] = 1;
                            macs[d] = op.mac;
                            head[d] = 0;
                            count[d] = 0;
                        end
                    end
                    if (d < 0) begin
                        r.status = ST_FULL;
                        r.avg = NO_DATA_X16;
                    end else begin
                        if (count[d] >= DEPTH) begin
                            head[d] = (head[d] + 1) % DEPTH;
                            count[d] = DEPTH - 1;
                        end
                        rssi_mem[d][(head[d] + count[d]) % DEPTH] = op.rssi;
                        stamp_mem[d][(head[d] + count[d]) % DEPTH] = op.now_sec;
                        count[d]++;
                        r.avg = mean_x16(d);
                        r.cnt = SCNT_W'(count[d]);
                    end
                end
                MODE_QUERY: begin
                    d = lookup(op.mac);
                    if (d < 0) begin
                        r.status = ST_UNKNOWN;
                        r.avg = NO_DATA_X16;
                    end else if (count[d] == 0) begin
                        r.status = ST_EMPTY;
                        r.avg = NO_DATA_X16;
                    end else begin
                        r.avg = mean_x16(d);
                        r.cnt = SCNT_W'(count[d]);
                    end
                end
                MODE_AGE: begin
                    f = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!used[i]) continue;
                        while (count[i] > 0) begin
                            age = longint'(op.now_sec) - longint'(stamp_mem[i][head[i]]);
                            if (age <= longint'(max_age)) break;
                            head[i] = (head[i] + 1) % DEPTH;
                            count[i]--;
                            f++;
                        end
                    end
                    r.removed = RCNT_W'(f);
                end
                default: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        used[i] = 0;
                        head[i] = 0;
                        count[i] = 0;
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check(t_res got);
            t_res exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d avg=%0d", $time,
                         got.status, $signed(got.avg));
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.avg !== exp.avg) begin
                $display("%0t: average_x16 exp %0d got %0d", $time,
                         $signed(exp.avg), $signed(got.avg));
                errors++;
            end
            if (got.cnt !== exp.cnt) begin
                $display("%0t: sample_count exp %0d got %0d", $time, exp.cnt, got.cnt);
                errors++;
            end
            if (got.removed !== exp.removed) begin
                $display("%0t: removed_count exp %0d got %0d", $time,
                         exp.removed, got.removed);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [1:0]         i_mode = MODE_CLEAR;
    logic [MAC_W-1:0]   i_mac = '0;
    logic signed [RSSI_W-1:0] i_rssi = '0;
    logic [TIME_W-1:0]  i_now_sec = '0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [1:0]         o_status;
    logic signed [AVG_W-1:0] o_average_x16;
    logic [SCNT_W-1:0]  o_sample_count;
    logic [RCNT_W-1:0]  o_removed_count;
    logic               i_cfg_we = 0;
    logic [AGE_W-1:0]   i_cfg_data = '0;

    window_table_scoreboard sb = new();
    longint cycles = 0;
    logic [MAC_W-1:0] mac_pool [8];
    logic [TIME_W-1:0] clock_sec;

    rssi_device_window_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_mac(i_mac), .i_rssi(i_rssi), .i_now_sec(i_now_sec),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_average_x16(o_average_x16),
        .o_sample_count(o_sample_count), .o_removed_count(o_removed_count),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // output side: random stall, check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check('{o_status, o_average_x16, o_sample_count, o_removed_count});
        if (i_rst_n) i_ready <= ($urandom_range(0, 99) < 70);
    end

    // valid stays high after a transfer only when the next item follows at once
    task automatic send(logic [1:0] mode, logic [MAC_W-1:0] mac, logic [7:0] rssi,
                        logic [TIME_W-1:0] now);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        i_mode <= mode;
        i_mac <= mac;
        i_rssi <= rssi;
        i_now_sec <= now;
        do @(posedge i_clk); while (!o_ready);
        sb.note_op('{mode, mac, rssi, now});
    endtask

    task automatic write_age(logic [AGE_W-1:0] v);
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.max_age = v;
    endtask

    // one random operation, mostly on a small set of known devices
    task automatic random_op();
        int p;
        logic [MAC_W-1:0] m;
        p = $urandom_range(0, 99);
        m = ($urandom_range(0, 9) < 8) ? mac_pool[$urandom_range(0, 7)]
                                       : MAC_W'({$urandom, $urandom});
        clock_sec += $urandom_range(0, 2);
        if (p < 60) send(MODE_RECORD, m, 8'($urandom), clock_sec - $urandom_range(0, 3));
        else if (p < 85) send(MODE_QUERY, m, 8'($urandom), clock_sec);
        else if (p < 97) send(MODE_AGE, m, 8'($urandom), clock_sec);
        else send(MODE_CLEAR, m, 8'($urandom), clock_sec);
    endtask

    initial begin
        logic [AGE_W-1:0] ages [5];
        ages = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd10};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: unknown query, extremes, window wrap, full table, age, clear
        send(MODE_QUERY, 48'hFFFF_FFFF_FFFF, 8'h00, 32'd0);
        send(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF);
        send(MODE_RECORD, 48'h0, 8'h80, 32'd0);
        send(MODE_RECORD, 48'h0, 8'h81, 32'd1);
        send(MODE_QUERY, 48'h0, 8'hFF, 32'd2);
        for (int i = 0; i < 34; i++)
            send(MODE_RECORD, 48'h0, (i % 2) ? 8'h80 : 8'h7F, 32'(i + 2));
        for (int i = 2; i < 17; i++)
            send(MODE_RECORD, 48'(i), 8'hC4, 32'd5);
        send(MODE_RECORD, 48'hAAAA_5555_AAAA, 8'h01, 32'd5);
        send(MODE_AGE, 48'h0, 8'h00, 32'd100);
        send(MODE_QUERY, 48'h2, 8'h00, 32'd100);
        send(MODE_AGE, 48'h0, 8'h00, 32'hFFFF_FFFF);
        send(MODE_CLEAR, 48'h0, 8'h00, 32'd0);
        send(MODE_QUERY, 48'h0, 8'h00, 32'd0);

        // random phases under several age settings
        clock_sec = $urandom;
        for (int ph = 0; ph < 5; ph++) begin
            write_age(ages[ph]);
            for (int j = 0; j < 8; j++) mac_pool[j] = MAC_W'({$urandom, $urandom});
            for (int n = 0; n < 340; n++) random_op();
        end
        i_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
